// File: src/drce_pkg.sv
`timescale 1ns / 1ps

package drce_pkg;

   // Screen size in pixels
   localparam int SCREEN_WIDTH  = 320;
   localparam int SCREEN_HEIGHT = 240;

   localparam logic signed [15:0] SCREEN_W_S = 16'(SCREEN_WIDTH);
   localparam logic signed [15:0] SCREEN_H_S = 16'(SCREEN_HEIGHT);

   // Last glyph column and row index (5x7 dots)
   localparam logic [2:0] GLYPH_LAST_COL = 3'd4;
   localparam logic [2:0] GLYPH_LAST_ROW = 3'd6;

   typedef enum logic [1:0] {
      CMD_FILL   = 2'd0,
      CMD_FRAME  = 2'd1,
      CMD_CHAR   = 2'd2,
      CMD_SCREEN = 2'd3
   } cmd_type;

   typedef enum logic {
      ST_RUN   = 1'b0,
      ST_FLUSH = 1'b1
   } state_type;

   // Decoded command as it waits between the front and back parts
   typedef struct packed {
      cmd_type            cmd;
      logic signed [11:0] pos_x;
      logic signed [11:0] pos_y;
      logic signed [11:0] width;
      logic signed [11:0] height;
      logic [10:0]        thickness;
      logic [3:0]         scale;
      logic [15:0]        color;
      logic [39:0]        glyph;    // five columns of eight bits, column 0 lowest
      logic signed [13:0] alt_x;    // pos_x + width - thickness
      logic signed [13:0] alt_y;    // pos_y + height - thickness
   } entry_type;

   // 5x7 font, column-major, bit 0 of a column is the top row.
   // Lower case is folded to upper case; anything unknown draws blank.
   function automatic logic [39:0] glyph_bits(logic [7:0] code);
      logic [7:0]  up;
      logic [39:0] bits;
      up = code;
      if (code >= 8'h61 && code <= 8'h7A) begin
         up = code - 8'h20;
      end
      unique case (up)
         8'h2D:   bits = 40'h0808080808;
         8'h2E:   bits = 40'h0000606000;
         8'h2F:   bits = 40'h0204081020;
         8'h30:   bits = 40'h3E4549513E;
         8'h31:   bits = 40'h00407F4200;
         8'h32:   bits = 40'h4649516142;
         8'h33:   bits = 40'h314B454121;
         8'h34:   bits = 40'h107F121418;
         8'h35:   bits = 40'h3945454527;
         8'h36:   bits = 40'h3049494A3C;
         8'h37:   bits = 40'h0305097101;
         8'h38:   bits = 40'h3649494936;
         8'h39:   bits = 40'h1E29494906;
         8'h3A:   bits = 40'h0000363600;
         8'h41:   bits = 40'h7E1111117E;
         8'h42:   bits = 40'h364949497F;
         8'h43:   bits = 40'h224141413E;
         8'h44:   bits = 40'h1C2241417F;
         8'h45:   bits = 40'h414949497F;
         8'h46:   bits = 40'h010909097F;
         8'h47:   bits = 40'h7A4949413E;
         8'h48:   bits = 40'h7F0808087F;
         8'h49:   bits = 40'h00417F4100;
         8'h4A:   bits = 40'h013F414020;
         8'h4B:   bits = 40'h412214087F;
         8'h4C:   bits = 40'h404040407F;
         8'h4D:   bits = 40'h7F020C027F;
         8'h4E:   bits = 40'h7F1008047F;
         8'h4F:   bits = 40'h3E4141413E;
         8'h50:   bits = 40'h060909097F;
         8'h51:   bits = 40'h5E2151413E;
         8'h52:   bits = 40'h462919097F;
         8'h53:   bits = 40'h3149494946;
         8'h54:   bits = 40'h01017F0101;
         8'h55:   bits = 40'h3F4040403F;
         8'h56:   bits = 40'h1F2040201F;
         8'h57:   bits = 40'h7F2018207F;
         8'h58:   bits = 40'h6314081463;
         8'h59:   bits = 40'h0708700807;
         8'h5A:   bits = 40'h4345495161;
         default: bits = 40'h0000000000;
      endcase
      return bits;
   endfunction

endpackage

// File: src/drce_req_if.sv
`timescale 1ns / 1ps

interface drce_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic signed [11:0] pos_x;
   logic signed [11:0] pos_y;
   logic signed [11:0] width;
   logic signed [11:0] height;
   logic [10:0]        thickness;
   logic [7:0]         char_code;
   logic [3:0]         scale;
   logic [15:0]        color;

   modport source (output valid, output cmd, output pos_x, output pos_y, output width,
                   output height, output thickness, output char_code, output scale,
                   output color, input ready);
   modport sink (input valid, input cmd, input pos_x, input pos_y, input width,
                 input height, input thickness, input char_code, input scale,
                 input color, output ready);
endinterface

// File: src/drce_rsp_if.sv
`timescale 1ns / 1ps

interface drce_rsp_if;
   logic        valid;
   logic        ready;
   logic [12:0] rect_x0;
   logic [12:0] rect_y0;
   logic [12:0] rect_x1;
   logic [12:0] rect_y1;
   logic [15:0] fill_color;
   logic        empty_res;
   logic        last;

   modport source (output valid, output rect_x0, output rect_y0, output rect_x1,
                   output rect_y1, output fill_color, output empty_res, output last,
                   input ready);
   modport sink (input valid, input rect_x0, input rect_y0, input rect_x1,
                 input rect_y1, input fill_color, input empty_res, input last,
                 output ready);
endinterface

// File: src/draw_command_rect_expander_core.sv
`timescale 1ns / 1ps
// Draw-command rectangle expander.
// req_port takes one draw command per item (fill rectangle, frame, character,
// fill screen); rsp_port gives the screen-clipped rectangles it paints, in
// drawing order, with last set on the final one. A command that paints
// nothing gives one result with empty_res and last set and zero fields.
// Both channels use valid/ready; an item moves when both are high.
// The front decodes a command (glyph lookup, frame edges) into a two-entry
// queue, so new commands are taken while the back part is still busy.
// The back part walks one candidate rectangle per cycle unless the stalled
// output holds it, and closes each command with a closing step: a fill or
// fill-screen has one candidate, a frame four strips, a character 35 dots,
// so sustained rate is set by that sequencer. On an idle block a fill result
// passes queue, held rectangle and output register; any other rectangle is
// output once the next is found, or when its command closes.
// If the receiver stalls, the back part holds one finished rectangle plus
// the output register and waits; the queue then fills and ready drops.
// Synchronous reset empties the queue and drops any result in flight.
module draw_command_rect_expander_core
   import drce_pkg::*;
(
   input logic        clock,
   input logic        reset,
   drce_req_if.sink   req_port,
   drce_rsp_if.source rsp_port
);

   logic      q_full;
   logic      q_push;
   entry_type q_entry;
   logic      q_pop;
   logic      head_valid;
   entry_type head_entry;

   drce_front u_front (
      .req_port (req_port),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   drce_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   drce_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (q_pop),
      .rsp_port   (rsp_port)
   );

endmodule

// File: src/drce_front.sv
`timescale 1ns / 1ps

module drce_front
   import drce_pkg::*;
(
   drce_req_if.sink  req_port,
   input  logic      q_full,
   output logic      q_push,
   output entry_type q_entry
);

   logic signed [13:0] x_ext;
   logic signed [13:0] y_ext;
   logic signed [13:0] w_ext;
   logic signed [13:0] h_ext;
   logic signed [13:0] t_ext;

   // Accept whenever the queue has room
   assign req_port.ready = !q_full;
   assign q_push         = req_port.valid && !q_full;

   // Widen operands for the far-edge strips of a frame
   assign x_ext = {{2{req_port.pos_x[11]}}, req_port.pos_x};
   assign y_ext = {{2{req_port.pos_y[11]}}, req_port.pos_y};
   assign w_ext = {{2{req_port.width[11]}}, req_port.width};
   assign h_ext = {{2{req_port.height[11]}}, req_port.height};
   assign t_ext = {3'b000, req_port.thickness};

   // Classify the command and look up the glyph
   always_comb begin
      q_entry.cmd       = cmd_type'(req_port.cmd);
      q_entry.pos_x     = req_port.pos_x;
      q_entry.pos_y     = req_port.pos_y;
      q_entry.width     = req_port.width;
      q_entry.height    = req_port.height;
      q_entry.thickness = req_port.thickness;
      q_entry.scale     = req_port.scale;
      q_entry.color     = req_port.color;
      q_entry.glyph     = glyph_bits(req_port.char_code);
      q_entry.alt_x     = x_ext + w_ext - t_ext;
      q_entry.alt_y     = y_ext + h_ext - t_ext;
   end

endmodule

// File: src/drce_queue.sv
`timescale 1ns / 1ps

module drce_queue
   import drce_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head_entry
);

   entry_type  slots_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign full       = count_ff[1];
   assign head_valid = count_ff != 2'd0;
   assign head_entry = slots_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming item
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: src/drce_back.sv
`timescale 1ns / 1ps

module drce_back
   import drce_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  entry_type   head_entry,
   output logic        pop,
   drce_rsp_if.source  rsp_port
);

   localparam logic [2:0] STRIP_TOP    = 3'd0;
   localparam logic [2:0] STRIP_BOTTOM = 3'd1;
   localparam logic [2:0] STRIP_LEFT   = 3'd2;
   localparam logic [2:0] STRIP_RIGHT  = 3'd3;

   state_type   state_ff;
   state_type   state_in;
   logic [2:0]  col_ff;
   logic [2:0]  col_in;
   logic [2:0]  row_ff;
   logic [2:0]  row_in;

   // Held rectangle, sent once the next one or the end is known
   logic        pend_valid_ff;
   logic        pend_valid_in;
   logic [12:0] pend_x0_ff, pend_y0_ff, pend_x1_ff, pend_y1_ff;
   logic        pend_load;

   // Output register
   logic        out_valid_ff;
   logic        out_valid_in;
   logic        out_load;
   logic        out_from_pend;
   logic        out_last;
   logic [12:0] out_x0_ff, out_y0_ff, out_x1_ff, out_y1_ff;
   logic [15:0] out_color_ff;
   logic        out_empty_ff;
   logic        out_last_ff;

   logic signed [15:0] cx, cy, cw, ch;
   logic signed [15:0] x_ext, y_ext, w_ext, h_ext, t_ext, s_ext;
   logic signed [15:0] ex1, ey1;
   logic signed [15:0] clip_x0, clip_y0, clip_x1, clip_y1;
   logic [6:0]  xoff, yoff;
   logic        dot;
   logic        hit;
   logic        last_step;
   logic        out_free;

   assign x_ext = {{4{head_entry.pos_x[11]}}, head_entry.pos_x};
   assign y_ext = {{4{head_entry.pos_y[11]}}, head_entry.pos_y};
   assign w_ext = {{4{head_entry.width[11]}}, head_entry.width};
   assign h_ext = {{4{head_entry.height[11]}}, head_entry.height};
   assign t_ext = {5'b00000, head_entry.thickness};
   assign s_ext = {12'h000, head_entry.scale};
   assign xoff  = 7'(col_ff) * 7'(head_entry.scale);
   assign yoff  = 7'(row_ff) * 7'(head_entry.scale);

   // Form the candidate rectangle of the current step
   always_comb begin
      cx  = 16'sd0;
      cy  = 16'sd0;
      cw  = SCREEN_W_S;
      ch  = SCREEN_H_S;
      dot = 1'b1;
      last_step = 1'b1;
      unique case (head_entry.cmd)
         CMD_FILL: begin
            cx = x_ext;
            cy = y_ext;
            cw = w_ext;
            ch = h_ext;
         end
         CMD_FRAME: begin
            last_step = row_ff == STRIP_RIGHT;
            unique case (row_ff)
               STRIP_TOP: begin
                  cx = x_ext;
                  cy = y_ext;
                  cw = w_ext;
                  ch = t_ext;
               end
               STRIP_BOTTOM: begin
                  cx = x_ext;
                  cy = {{2{head_entry.alt_y[13]}}, head_entry.alt_y};
                  cw = w_ext;
                  ch = t_ext;
               end
               STRIP_LEFT: begin
                  cx = x_ext;
                  cy = y_ext;
                  cw = t_ext;
                  ch = h_ext;
               end
               default: begin
                  cx = {{2{head_entry.alt_x[13]}}, head_entry.alt_x};
                  cy = y_ext;
                  cw = t_ext;
                  ch = h_ext;
               end
            endcase
         end
         CMD_CHAR: begin
            last_step = col_ff == GLYPH_LAST_COL && row_ff == GLYPH_LAST_ROW;
            cx  = x_ext + {9'h000, xoff};
            cy  = y_ext + {9'h000, yoff};
            cw  = s_ext;
            ch  = s_ext;
            dot = head_entry.glyph[{col_ff, row_ff}];
         end
         default: begin
            cx = 16'sd0;
            cy = 16'sd0;
            cw = SCREEN_W_S;
            ch = SCREEN_H_S;
         end
      endcase
   end

   // Clip to the screen and drop empty rectangles
   always_comb begin
      ex1     = cx + cw;
      ey1     = cy + ch;
      clip_x0 = (cx < 16'sd0) ? 16'sd0 : cx;
      clip_y0 = (cy < 16'sd0) ? 16'sd0 : cy;
      clip_x1 = (ex1 > SCREEN_W_S) ? SCREEN_W_S : ex1;
      clip_y1 = (ey1 > SCREEN_H_S) ? SCREEN_H_S : ey1;
      hit     = dot && (clip_x0 < clip_x1) && (clip_y0 < clip_y1);
   end

   assign out_free = !out_valid_ff || rsp_port.ready;

   // Sequence the steps of one command and close it with a final result
   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      pend_valid_in = pend_valid_ff;
      pend_load     = 1'b0;
      out_load      = 1'b0;
      out_from_pend = 1'b1;
      out_last      = 1'b0;
      pop           = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            if (head_valid && !(hit && pend_valid_ff && !out_free)) begin
               if (hit) begin
                  pend_load     = 1'b1;
                  pend_valid_in = 1'b1;
                  out_load      = pend_valid_ff;
               end
               if (last_step) begin
                  state_in = ST_FLUSH;
               end else if (head_entry.cmd == CMD_CHAR && row_ff == GLYPH_LAST_ROW) begin
                  row_in = 3'd0;
                  col_in = col_ff + 3'd1;
               end else begin
                  row_in = row_ff + 3'd1;
               end
            end
         end
         default: begin
            if (out_free) begin
               out_load      = 1'b1;
               out_from_pend = pend_valid_ff;
               out_last      = 1'b1;
               pend_valid_in = 1'b0;
               pop           = 1'b1;
               col_in        = 3'd0;
               row_in        = 3'd0;
               state_in      = ST_RUN;
            end
         end
      endcase
      out_valid_in = out_load || (out_valid_ff && !rsp_port.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         col_ff        <= 3'd0;
         row_ff        <= 3'd0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Hold the clipped rectangle
   always_ff @(posedge clock) begin
      if (pend_load) begin
         pend_x0_ff <= clip_x0[12:0];
         pend_y0_ff <= clip_y0[12:0];
         pend_x1_ff <= clip_x1[12:0];
         pend_y1_ff <= clip_y1[12:0];
      end
   end

   // Load the output register: held rectangle, or the empty marker
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_last_ff <= out_last;
         if (out_from_pend) begin
            out_x0_ff    <= pend_x0_ff;
            out_y0_ff    <= pend_y0_ff;
            out_x1_ff    <= pend_x1_ff;
            out_y1_ff    <= pend_y1_ff;
            out_color_ff <= head_entry.color;
            out_empty_ff <= 1'b0;
         end else begin
            out_x0_ff    <= 13'd0;
            out_y0_ff    <= 13'd0;
            out_x1_ff    <= 13'd0;
            out_y1_ff    <= 13'd0;
            out_color_ff <= 16'd0;
            out_empty_ff <= 1'b1;
         end
      end
   end

   assign rsp_port.valid      = out_valid_ff;
   assign rsp_port.rect_x0    = out_x0_ff;
   assign rsp_port.rect_y0    = out_y0_ff;
   assign rsp_port.rect_x1    = out_x1_ff;
   assign rsp_port.rect_y1    = out_y1_ff;
   assign rsp_port.fill_color = out_color_ff;
   assign rsp_port.empty_res  = out_empty_ff;
   assign rsp_port.last       = out_last_ff;

endmodule
